>>> src/im_pkg.sv
// ----------------------------------------------------------------------------
// im_pkg: shared types for the interval merge block
// Holds the sequencer states and the layout of one stored interval.
// ----------------------------------------------------------------------------
package im_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] e;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_MRG_NEXT,
        S_MRG_USE,
        S_MRG_MAX
    } t_state;

endpackage

>>> src/im_cmp.sv
// ----------------------------------------------------------------------------
// im_cmp: shared signed comparator
// The one compare unit that the sequencer uses for both sorting and merging.
// ----------------------------------------------------------------------------
module im_cmp (
    input  logic signed [im_pkg::DATA_W-1:0] i_a,
    input  logic signed [im_pkg::DATA_W-1:0] i_b,
    output logic                             o_gt
);
    import im_pkg::*;

    assign o_gt = (i_a > i_b);

endmodule

>>> src/im_store.sv
// ----------------------------------------------------------------------------
// im_store: interval buffer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module im_store #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  im_pkg::t_entry        i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output im_pkg::t_entry        o_rdata
);
    import im_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/interval_merge.sv
// ----------------------------------------------------------------------------
// interval_merge: sorts a set of intervals by begin and merges overlaps
// Each accepted item within CAPACITY is placed into a sorted buffer by
// insertion, one entry per cycle; the item that closes a set starts a sweep
// that emits the merged intervals in order, the final one marked as last.
// ----------------------------------------------------------------------------
// An item that goes in front of held intervals keeps busy high while the
// buffer is read and shifted one entry per cycle; the first item of a set,
// and an item that is dropped, is taken without raising busy unless it
// closes the set. After the closing item the sweep reads each held interval
// in turn, with an extra step for each that overlaps the current one and a
// final step to emit the last, all through one shared comparator. Results
// come out on a one-cycle strobe and the receiver cannot stall them; items
// beyond CAPACITY are dropped and flagged on every result of that set.
module interval_merge #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [im_pkg::DATA_W-1:0] i_interval_begin,
    input  logic signed [im_pkg::DATA_W-1:0] i_interval_end,
    input  logic                             i_last_in_set,
    output logic                             o_valid,
    output logic signed [im_pkg::DATA_W-1:0] o_merged_begin,
    output logic signed [im_pkg::DATA_W-1:0] o_merged_end,
    output logic                             o_last_merged,
    output logic                             o_overflow
);
    import im_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = $clog2(CAPACITY);

    t_state              r_state, n_state;
    logic   [CW-1:0]     r_count, n_count;
    logic                r_dropped, n_dropped;
    logic   [AW-1:0]     r_j, n_j;
    logic   [CW-1:0]     r_idx, n_idx;
    t_entry              r_key, n_key;
    logic                r_last, n_last;
    t_entry              r_cur, n_cur;
    logic                r_valid, n_valid;
    t_entry              r_out, n_out;
    logic                r_out_last, n_out_last;
    logic                r_out_ovf, n_out_ovf;

    logic                we;
    logic   [AW-1:0]     waddr;
    t_entry              wdata;
    logic   [AW-1:0]     raddr;
    t_entry              rdata;
    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic                cmp_gt;
    logic                accept;

    im_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    im_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_last     <= n_last;
        r_cur      <= n_cur;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_j        = r_j;
        n_idx      = r_idx;
        n_key      = r_key;
        n_last     = r_last;
        n_cur      = r_cur;
        n_valid    = 1'b0;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        we         = 1'b0;
        waddr      = r_j;
        wdata      = r_key;
        raddr      = '0;
        cmp_a      = rdata.b;
        cmp_b      = r_key.b;

        unique case (r_state)
            S_IDLE: begin
                raddr = r_count[AW-1:0] - AW'(1);
                if (accept) begin
                    n_key.b = i_interval_begin;
                    n_key.e = i_interval_end;
                    n_last  = i_last_in_set;
                    n_idx   = '0;
                    if (r_count < CW'(CAPACITY)) begin
                        n_j = r_count[AW-1:0];
                        if (r_count == '0) begin
                            we      = 1'b1;
                            waddr   = '0;
                            wdata.b = i_interval_begin;
                            wdata.e = i_interval_end;
                            n_count = r_count + CW'(1);
                            n_state = i_last_in_set ? S_MRG_NEXT : S_IDLE;
                        end else begin
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        n_dropped = 1'b1;
                        n_state   = i_last_in_set ? S_MRG_NEXT : S_IDLE;
                    end
                end
            end
            S_INS_CMP: begin
                cmp_a = rdata.b;
                cmp_b = r_key.b;
                raddr = r_j - AW'(2);
                if (cmp_gt) begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_j   = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_MRG_NEXT : S_IDLE;
                end
            end
            S_INS_PUT: begin
                we      = 1'b1;
                n_count = r_count + CW'(1);
                n_state = r_last ? S_MRG_NEXT : S_IDLE;
            end
            S_MRG_NEXT: begin
                raddr = r_idx[AW-1:0];
                if (r_idx == r_count) begin
                    n_valid    = 1'b1;
                    n_out      = r_cur;
                    n_out_last = 1'b1;
                    n_out_ovf  = r_dropped;
                    n_count    = '0;
                    n_dropped  = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_MRG_USE;
                end
            end
            S_MRG_USE: begin
                cmp_a = rdata.b;
                cmp_b = r_cur.e;
                if (r_idx == '0) begin
                    n_cur   = rdata;
                    n_idx   = r_idx + CW'(1);
                    n_state = S_MRG_NEXT;
                end else if (!cmp_gt) begin
                    n_key.e = rdata.e;
                    n_state = S_MRG_MAX;
                end else begin
                    n_valid    = 1'b1;
                    n_out      = r_cur;
                    n_out_last = 1'b0;
                    n_out_ovf  = r_dropped;
                    n_cur      = rdata;
                    n_idx      = r_idx + CW'(1);
                    n_state    = S_MRG_NEXT;
                end
            end
            S_MRG_MAX: begin
                cmp_a = r_key.e;
                cmp_b = r_cur.e;
                if (cmp_gt) begin
                    n_cur.e = r_key.e;
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_MRG_NEXT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_merged_begin = r_out.b;
    assign o_merged_end   = r_out.e;
    assign o_last_merged  = r_out_last;
    assign o_overflow     = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_last_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_merged |=> !o_valid)
        else $error("result emitted after the last merged interval");

    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_merged |-> busy)
        else $error("sweep ended without a last merged interval");

    a_close_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_in_set |=> busy)
        else $error("closing item did not start the sweep");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the interval merge block
// Sends sets of intervals through the start/busy handshake and predicts
// the merged output of each set with a stable sort and a single sweep. Every
// strobed result is checked against the oldest predicted one. Directed sets
// cover extreme values, touching, nested, reversed and equal-begin
// intervals and a full or overflowing buffer. Random sets follow, with and
// without idle gaps on the sending side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import im_pkg::*;

    localparam int unsigned SET_CAP      = 32;
    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 4 * SET_CAP + 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned RANDOM_ITEMS = 80;
    localparam int unsigned STEADY_ITEMS = 30;

    typedef logic signed [DATA_W-1:0] t_value;

    localparam t_value MAX_V = 32'sh7fffffff;
    localparam t_value MIN_V = 32'sh80000000;

    typedef struct {
        t_value b;
        t_value e;
        logic   last;
        logic   ovf;
    } t_merged;

    typedef enum int {
        SPREAD_NARROW,
        SPREAD_WIDE,
        SPREAD_EDGE,
        SPREAD_MIXED
    } t_spread;

    logic   i_clk            = 1'b0;
    logic   i_rst_n          = 1'b0;
    logic   start            = 1'b0;
    t_value i_interval_begin = '0;
    t_value i_interval_end   = '0;
    logic   i_last_in_set    = 1'b0;
    logic   busy;
    logic   o_valid;
    t_value o_merged_begin;
    t_value o_merged_end;
    logic   o_last_merged;
    logic   o_overflow;

    t_value      held_begin [SET_CAP];
    t_value      held_end   [SET_CAP];
    int unsigned held_count   = 0;
    logic        held_dropped = 1'b0;
    t_merged     pending_merged[$];

    bit          gaps_on        = 1'b0;
    int unsigned fault_count    = 0;
    int unsigned merged_checked = 0;
    int unsigned items_sent     = 0;
    int unsigned sets_sent      = 0;
    int unsigned overflow_sets  = 0;
    int unsigned cycle_count    = 0;

    interval_merge #(
        .CAPACITY(SET_CAP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_interval_begin(i_interval_begin),
        .i_interval_end  (i_interval_end),
        .i_last_in_set   (i_last_in_set),
        .o_valid         (o_valid),
        .o_merged_begin  (o_merged_begin),
        .o_merged_end    (o_merged_end),
        .o_last_merged   (o_last_merged),
        .o_overflow      (o_overflow)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void queue_merged(input t_value b, input t_value e, input logic last,
                                         input logic ovf);
        t_merged item;
        item = '{b: b, e: e, last: last, ovf: ovf};
        pending_merged.insert(pending_merged.size(), item);
    endfunction

    function automatic void predict_merge(input t_value b, input t_value e, input logic last);
        t_value      key_b;
        t_value      key_e;
        t_value      cur_b;
        t_value      cur_e;
        int unsigned j;
        if (held_count < SET_CAP) begin
            held_begin[held_count] = b;
            held_end[held_count]   = e;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!last) return;
        for (int unsigned i = 1; i < held_count; i++) begin
            key_b = held_begin[i];
            key_e = held_end[i];
            j = i;
            while (j > 0 && held_begin[j-1] > key_b) begin
                held_begin[j] = held_begin[j-1];
                held_end[j]   = held_end[j-1];
                j--;
            end
            held_begin[j] = key_b;
            held_end[j]   = key_e;
        end
        cur_b = held_begin[0];
        cur_e = held_end[0];
        for (int unsigned i = 1; i < held_count; i++) begin
            if (cur_e >= held_begin[i]) begin
                if (held_end[i] > cur_e) cur_e = held_end[i];
            end else begin
                queue_merged(cur_b, cur_e, 1'b0, held_dropped);
                cur_b = held_begin[i];
                cur_e = held_end[i];
            end
        end
        queue_merged(cur_b, cur_e, 1'b1, held_dropped);
        if (held_dropped) overflow_sets++;
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    task automatic send_interval(input t_value b, input t_value e, input logic last);
        start            <= 1'b1;
        i_interval_begin <= b;
        i_interval_end   <= e;
        i_last_in_set    <= last;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_merge(b, e, last);
        items_sent++;
        if (last) sets_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start            <= 1'b0;
            i_interval_begin <= $urandom;
            i_interval_end   <= $urandom;
            i_last_in_set    <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    function automatic void random_interval(input t_spread spread, output t_value b,
                                            output t_value e);
        t_spread s;
        s = spread;
        if (s == SPREAD_MIXED) s = t_spread'($urandom_range(0, 2));
        case (s)
            SPREAD_NARROW: begin
                b = $signed($urandom_range(0, 200)) - 100;
                if ($urandom_range(0, 7) == 0) e = b - $urandom_range(1, 10);
                else e = b + $urandom_range(0, 20);
            end
            SPREAD_EDGE: begin
                b = $urandom_range(0, 1) ? MAX_V - $urandom_range(0, 15)
                                         : MIN_V + $urandom_range(0, 15);
                e = $urandom_range(0, 1) ? b + $urandom_range(0, 15)
                                         : ($urandom_range(0, 1) ? MAX_V : MIN_V);
            end
            default: begin
                b = $urandom;
                e = $urandom_range(0, 1) ? t_value'($urandom) : b + $urandom_range(0, 1 << 20);
            end
        endcase
    endfunction

    task automatic send_random_set(input int unsigned n, input t_spread spread);
        t_value b;
        t_value e;
        for (int unsigned i = 0; i < n; i++) begin
            random_interval(spread, b, e);
            send_interval(b, e, i == n - 1);
        end
    endtask

    function automatic int unsigned pick_set_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 8);
        if (r < 17) return $urandom_range(9, SET_CAP - 1);
        return $urandom_range(SET_CAP, SET_CAP + 3);
    endfunction

    task automatic test_single_extremes();
        send_interval(MIN_V, MAX_V, 1'b1);
        send_interval(MAX_V, MIN_V, 1'b1);
        send_interval('0, '0, 1'b1);
        send_interval(MAX_V, MAX_V, 1'b1);
    endtask

    task automatic test_touching_and_disjoint();
        send_interval(5, 9, 1'b0);
        send_interval(1, 5, 1'b0);
        send_interval(10, 12, 1'b0);
        send_interval(13, 13, 1'b1);
    endtask

    task automatic test_equal_begins();
        send_interval(5, 3, 1'b0);
        send_interval(5, 10, 1'b0);
        send_interval(20, 25, 1'b1);
        send_interval(5, 10, 1'b0);
        send_interval(5, 3, 1'b0);
        send_interval(8, 6, 1'b1);
    endtask

    task automatic test_nested_and_reversed();
        send_interval(-1, MIN_V, 1'b0);
        send_interval(0, 1, 1'b0);
        send_interval(MIN_V, MAX_V, 1'b0);
        send_interval(MAX_V, MAX_V, 1'b0);
        send_interval(MIN_V, MIN_V, 1'b1);
    endtask

    task automatic test_capacity();
        send_random_set(SET_CAP, SPREAD_NARROW);
        send_random_set(SET_CAP + 1, SPREAD_NARROW);
        send_random_set(SET_CAP + 3, SPREAD_MIXED);
    endtask

    task automatic test_random_sets();
        int unsigned first;
        t_spread     spread;
        first   = items_sent;
        gaps_on = 1'b1;
        while (items_sent - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: spread = SPREAD_NARROW;
                6:                spread = SPREAD_WIDE;
                7:                spread = SPREAD_EDGE;
                default:          spread = SPREAD_MIXED;
            endcase
            send_random_set(pick_set_size(), spread);
        end
    endtask

    task automatic test_back_to_back();
        int unsigned first;
        first   = items_sent;
        gaps_on = 1'b0;
        while (items_sent - first < STEADY_ITEMS) begin
            send_random_set($urandom_range(1, 8), SPREAD_MIXED);
        end
    endtask

    always @(posedge i_clk) begin
        t_merged want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_merged.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("Unexpected result: begin %0d end %0d last %b overflow %b",
                             o_merged_begin, o_merged_end, o_last_merged, o_overflow);
                end
            end else begin
                want = pending_merged.pop_front();
                merged_checked++;
                if (o_merged_begin !== want.b || o_merged_end !== want.e
                        || o_last_merged !== want.last || o_overflow !== want.ovf) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("Mismatch: expected begin %0d end %0d last %b overflow %b",
                                 want.b, want.e, want.last, want.ovf);
                        $display("          actual   begin %0d end %0d last %b overflow %b",
                                 o_merged_begin, o_merged_end, o_last_merged, o_overflow);
                    end
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_extremes();
        test_touching_and_disjoint();
        test_equal_begins();
        test_nested_and_reversed();
        test_capacity();
        test_random_sets();
        test_back_to_back();
        start <= 1'b0;
        while (pending_merged.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_merged.size() != 0) begin
            fault_count++;
            $display("%0d expected results never arrived", pending_merged.size());
        end
        $display("Sent %0d intervals in %0d sets, %0d of them past capacity.",
                 items_sent, sets_sent, overflow_sets);
        $display("Checked %0d merged results, %0d faults.", merged_checked, fault_count);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/im_pkg.sv
src/im_cmp.sv
src/im_store.sv
src/interval_merge.sv
tb/testbench.sv
